@@ src/smpq_pkg.sv @@
// smpq_pkg: operation and status codes and fixed field widths of the sorted min priority queue.
// No dependencies; used by the channel interfaces and the top level.
`timescale 1ns / 1ps
`default_nettype none

package smpq_pkg;

   localparam int OP_W     = 2;
   localparam int STATUS_W = 3;
   localparam int COUNT_W  = 5;
   localparam int CAP_W    = 5;

   typedef logic [OP_W-1:0]     op_type;
   typedef logic [STATUS_W-1:0] status_type;
   typedef logic [COUNT_W-1:0]  count_type;
   typedef logic [CAP_W-1:0]    cap_type;

   localparam op_type OP_INSERT = 2'd0;
   localparam op_type OP_GET    = 2'd1;
   localparam op_type OP_CREATE = 2'd2;
   localparam op_type OP_DELETE = 2'd3;

   localparam status_type ST_OK          = 3'd0;
   localparam status_type ST_FULL        = 3'd1;
   localparam status_type ST_EMPTY       = 3'd2;
   localparam status_type ST_NOT_CREATED = 3'd3;
   localparam status_type ST_ALREADY     = 3'd4;

   localparam cap_type CAP_RESET = 5'd16;

endpackage

`default_nettype wire

@@ src/smpq_req_if.sv @@
// smpq_req_if: request channel of the priority queue (operation and value).
// Depends on smpq_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface smpq_req_if #(
   parameter int VALUE_WIDTH = 8
);
   import smpq_pkg::*;

   logic                   valid;
   logic                   ready;
   op_type                 op;
   logic [VALUE_WIDTH-1:0] value;

   modport source (output valid, output op, output value, input ready);
   modport sink   (input valid, input op, input value, output ready);
endinterface

`default_nettype wire

@@ src/smpq_rsp_if.sv @@
// smpq_rsp_if: response channel of the priority queue (status, value, count, flags).
// Depends on smpq_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface smpq_rsp_if #(
   parameter int VALUE_WIDTH = 8
);
   import smpq_pkg::*;

   logic                   valid;
   logic                   ready;
   status_type             status;
   logic [VALUE_WIDTH-1:0] value_out;
   count_type              count;
   logic                   full_res;
   logic                   empty_res;

   modport source (output valid, output status, output value_out, output count,
                   output full_res, output empty_res, input ready);
   modport sink   (input valid, input status, input value_out, input count,
                   input full_res, input empty_res, output ready);
endinterface

`default_nettype wire

@@ src/smpq_csr_if.sv @@
// smpq_csr_if: write channel for the capacity register.
// Depends on smpq_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface smpq_csr_if;
   import smpq_pkg::*;

   logic    valid;
   logic    ready;
   cap_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ src/sorted_min_priority_queue.sv @@
// sorted_min_priority_queue: bounded min-first queue kept sorted in a circular memory.
// Depends on smpq_pkg, smpq_req_if, smpq_rsp_if, smpq_csr_if.
//
//   channel   direction  handshake      payload
//   req_ch    in         valid/ready    op, value
//   rsp_ch    out        valid/ready    status, value_out, count, full_res, empty_res
//   csr_ch    in         valid/ready    data (capacity, always ready)
//
// Create, delete and any failing request answer straight from the idle state; get does one
// memory read first. Insert walks down from the tail and moves each held value greater than
// the new one up by one place, then writes the new value into the hole that is left; an empty
// queue takes the new value at once. Each shifted value costs one read and one write-back.
// Synchronous active-high reset; no clearing pass, the store is only read where written.
// One request is in work at a time; a waiting response blocks new requests only when the
// response slot is full and not being taken.
`timescale 1ns / 1ps
`default_nettype none

module sorted_min_priority_queue #(
   parameter int DEPTH       = 16,
   parameter int VALUE_WIDTH = 8
) (
   input  wire        clock,
   input  wire        reset,
   smpq_req_if.sink   req_ch,
   smpq_rsp_if.source rsp_ch,
   smpq_csr_if.sink   csr_ch
);
   import smpq_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int SW = ((AW > COUNT_W) ? AW : COUNT_W) + 1;
   localparam cap_type CAP_MAX = CAP_W'((DEPTH < 31) ? DEPTH : 31);

   localparam logic [1:0] S_IDLE    = 2'd0;
   localparam logic [1:0] S_INS_RD  = 2'd1;
   localparam logic [1:0] S_INS_CMP = 2'd2;
   localparam logic [1:0] S_GET     = 2'd3;

   logic [1:0]             state_ff, state_in;
   logic                   defined_ff, defined_in;
   count_type              held_ff, held_in;
   cap_type                cap_ff, cap_in;
   cap_type                capacity_ff, capacity_in;
   logic [AW-1:0]          head_ff, head_in;
   count_type              idx_ff, idx_in;
   logic [VALUE_WIDTH-1:0] val_ff, val_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   status_type             status_ff, status_in;
   logic [VALUE_WIDTH-1:0] vout_ff, vout_in;
   count_type              count_ff, count_in;
   logic                   full_ff, full_in;
   logic                   empty_ff, empty_in;

   logic [VALUE_WIDTH-1:0] entries_mem [DEPTH];
   logic [VALUE_WIDTH-1:0] rd_data_ff;
   logic                   wr_en, rd_en;
   logic [AW-1:0]          wr_addr, rd_addr;
   logic [VALUE_WIDTH-1:0] wr_data;

   logic                   req_fire;
   logic                   load_rsp;
   status_type             st_n;
   logic [VALUE_WIDTH-1:0] vout_n;

   // queue position -> memory address, wrapping at DEPTH
   function automatic logic [AW-1:0] phys_addr(input logic [AW-1:0] base,
                                               input count_type ofs);
      logic [SW-1:0] sum;
      sum = SW'(base) + SW'(ofs);
      if (sum >= SW'(DEPTH))
         sum = sum - SW'(DEPTH);
      return sum[AW-1:0];
   endfunction

   assign csr_ch.ready = 1'b1;
   assign req_ch.ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ch.ready);
   assign req_fire     = req_ch.valid && req_ch.ready;

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.status    = status_ff;
   assign rsp_ch.value_out = vout_ff;
   assign rsp_ch.count     = count_ff;
   assign rsp_ch.full_res  = full_ff;
   assign rsp_ch.empty_res = empty_ff;

   always_comb begin
      state_in     = state_ff;
      defined_in   = defined_ff;
      held_in      = held_ff;
      cap_in       = cap_ff;
      capacity_in  = (csr_ch.valid && csr_ch.ready) ? csr_ch.data : capacity_ff;
      head_in      = head_ff;
      idx_in       = idx_ff;
      val_in       = val_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      status_in    = status_ff;
      vout_in      = vout_ff;
      count_in     = count_ff;
      full_in      = full_ff;
      empty_in     = empty_ff;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = '0;
      rd_en        = 1'b0;
      rd_addr      = '0;
      load_rsp     = 1'b0;
      st_n         = ST_OK;
      vout_n       = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               unique case (req_ch.op)
                  OP_INSERT: begin
                     if (!defined_ff) begin
                        st_n     = ST_NOT_CREATED;
                        load_rsp = 1'b1;
                     end else if (held_ff >= cap_ff) begin
                        st_n     = ST_FULL;
                        load_rsp = 1'b1;
                     end else begin
                        val_in   = req_ch.value;
                        idx_in   = held_ff;
                        state_in = S_INS_RD;
                     end
                  end
                  OP_GET: begin
                     if (!defined_ff) begin
                        st_n     = ST_NOT_CREATED;
                        load_rsp = 1'b1;
                     end else if (held_ff == '0) begin
                        st_n     = ST_EMPTY;
                        load_rsp = 1'b1;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = head_ff;
                        state_in = S_GET;
                     end
                  end
                  OP_CREATE: begin
                     load_rsp = 1'b1;
                     if (defined_ff) begin
                        st_n = ST_ALREADY;
                     end else begin
                        defined_in = 1'b1;
                        held_in    = '0;
                        head_in    = '0;
                        if (capacity_ff == '0)
                           cap_in = CAP_W'(1);
                        else if (capacity_ff > CAP_MAX)
                           cap_in = CAP_MAX;
                        else
                           cap_in = capacity_ff;
                     end
                  end
                  OP_DELETE: begin
                     load_rsp = 1'b1;
                     if (!defined_ff) begin
                        st_n = ST_NOT_CREATED;
                     end else begin
                        defined_in = 1'b0;
                        held_in    = '0;
                        cap_in     = '0;
                     end
                  end
               endcase
            end
         end
         S_INS_RD: begin
            if (idx_ff == '0) begin
               wr_en    = 1'b1;
               wr_addr  = head_ff;
               wr_data  = val_ff;
               held_in  = held_ff + COUNT_W'(1);
               load_rsp = 1'b1;
               state_in = S_IDLE;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = phys_addr(head_ff, idx_ff - COUNT_W'(1));
               state_in = S_INS_CMP;
            end
         end
         S_INS_CMP: begin
            // the hole sits at idx; the read of idx-1 never overlaps a pending write
            wr_en   = 1'b1;
            wr_addr = phys_addr(head_ff, idx_ff);
            if (rd_data_ff > val_ff) begin
               wr_data  = rd_data_ff;
               idx_in   = idx_ff - COUNT_W'(1);
               state_in = S_INS_RD;
            end else begin
               wr_data  = val_ff;
               held_in  = held_ff + COUNT_W'(1);
               load_rsp = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_GET: begin
            vout_n   = rd_data_ff;
            head_in  = phys_addr(head_ff, COUNT_W'(1));
            held_in  = held_ff - COUNT_W'(1);
            load_rsp = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase

      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         status_in    = st_n;
         vout_in      = vout_n;
         count_in     = held_in;
         full_in      = defined_in && (held_in == count_type'(cap_in));
         empty_in     = !defined_in || (held_in == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         defined_ff   <= 1'b0;
         held_ff      <= '0;
         cap_ff       <= '0;
         capacity_ff  <= CAP_RESET;
         head_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         defined_ff   <= defined_in;
         held_ff      <= held_in;
         cap_ff       <= cap_in;
         capacity_ff  <= capacity_in;
         head_ff      <= head_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      val_ff    <= val_in;
      status_ff <= status_in;
      vout_ff   <= vout_in;
      count_ff  <= count_in;
      full_ff   <= full_in;
      empty_ff  <= empty_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en)
         entries_mem[wr_addr] <= wr_data;
      if (rd_en)
         rd_data_ff <= entries_mem[rd_addr];
   end

   // an undefined queue holds nothing
   a_undef_empty: assert property (@(posedge clock) disable iff (reset)
      !defined_ff |-> (held_ff == '0))
      else $error("entries held while queue not created");

   a_held_le_cap: assert property (@(posedge clock) disable iff (reset)
      defined_ff |-> (held_ff <= cap_ff))
      else $error("held count above latched capacity");

   // the response slot stays free while a request is in work
   a_slot_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !rsp_valid_ff)
      else $error("response pending during multi-cycle request");

   a_get_dec: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_GET) |=> (held_ff == $past(held_ff) - COUNT_W'(1)) && rsp_valid_ff)
      else $error("get did not remove exactly one entry");

   a_cmp_after_rd: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_INS_CMP) |-> ($past(state_ff) == S_INS_RD))
      else $error("compare step without preceding read");

endmodule

`default_nettype wire
